### hw/rtl/defect_pixel_calibration_sequencer_defines.svh
// Assertion macros shared by the calibration sequencer RTL.
// Each macro expects signals named clk and rst in the scope of its use.
`ifndef DEFECT_PIXEL_CALIBRATION_SEQUENCER_DEFINES_SVH
`define DEFECT_PIXEL_CALIBRATION_SEQUENCER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define DPC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define DPC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/dpc_pkg.sv
`timescale 1ns / 1ps

package dpc_pkg;

  // Commands sent to the detection hardware
  typedef enum logic [2:0] {
    CMD_NONE    = 3'd0,
    CMD_START   = 3'd1,
    CMD_PROGRAM = 3'd2,
    CMD_DET_ON  = 3'd3,
    CMD_DET_OFF = 3'd4,
    CMD_EVAL    = 3'd5,
    CMD_ABORT   = 3'd6
  } cmd_e;

  // Step outcome
  typedef enum logic [2:0] {
    ST_RUN     = 3'd0,
    ST_SUCCESS = 3'd1,
    ST_TIMEOUT = 3'd2,
    ST_HIGHER  = 3'd3,
    ST_LOWER   = 3'd4
  } status_e;

  // Sequencer phase, named by the step taken when a frame arrives in it
  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_START    = 3'd1,
    PH_PROGRAM  = 3'd2,
    PH_DET_ON   = 3'd3,
    PH_DET_OFF  = 3'd4,
    PH_SETTLE   = 3'd5,
    PH_EVAL     = 3'd6,
    PH_HALT     = 3'd7
  } phase_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_UPPER_LIMIT = 2'd0,
    REG_LOWER_LIMIT = 2'd1,
    REG_MAX_TRIALS  = 2'd2,
    REG_START_THR   = 2'd3
  } reg_index_e;

  localparam int CFG_DATA_W = 16;

  localparam logic [15:0] UPPER_LIMIT_RESET = 16'd256;
  localparam logic [15:0] LOWER_LIMIT_RESET = 16'd64;
  localparam logic [7:0]  MAX_TRIALS_RESET  = 8'd200;
  localparam logic [7:0]  START_THR_RESET   = 8'h1F;

  typedef struct packed {
    logic        trigger;
    logic [15:0] defect_count;
  } item_t;

  typedef struct packed {
    cmd_e        command;
    logic [7:0]  threshold;
    status_e     status;
    logic        trigger_clear;
    logic        calibrating;
    logic [7:0]  trials;
  } result_t;

endpackage

### hw/rtl/defect_pixel_calibration_sequencer.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake                  Payload
// item      in         item_valid / item_ready    item_t   (trigger, defect_count)
// result    out        result_valid / result_ready result_t (command .. trials)
// cfg       in         cfg_we                     cfg_index, cfg_data
//
// One frame item yields one result, registered in the cycle after the transfer.
// A new item is taken every cycle while the result register is empty or drains
// in the same cycle; the single result register is the only stall point.
// Synchronous reset clears phase, trial count, threshold, the valid flag and
// loads the register defaults.

`include "defect_pixel_calibration_sequencer_defines.svh"

module defect_pixel_calibration_sequencer
  import dpc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_ready,
  input  item_t                 item,
  output logic                  result_valid,
  input  logic                  result_ready,
  output result_t               result,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Configuration registers
  logic [15:0] upper_limit;
  logic [15:0] lower_limit;
  logic [7:0]  max_trials;
  logic [7:0]  start_thr;

  // Sequencer state
  phase_e      phase, phase_next;
  logic [7:0]  trial_counter, trial_counter_next;
  logic [7:0]  search_thr, search_thr_next;
  logic        active, active_next;
  result_t     result_next;

  logic        item_xfer;

  assign item_ready = !result_valid || result_ready;
  assign item_xfer  = item_valid && item_ready;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      upper_limit <= UPPER_LIMIT_RESET;
      lower_limit <= LOWER_LIMIT_RESET;
      max_trials  <= MAX_TRIALS_RESET;
      start_thr   <= START_THR_RESET;
    end else if (cfg_we) begin
      case (reg_index_e'(cfg_index))
        REG_UPPER_LIMIT: upper_limit <= cfg_data[15:0];
        REG_LOWER_LIMIT: lower_limit <= cfg_data[15:0];
        REG_MAX_TRIALS:  max_trials  <= cfg_data[7:0];
        REG_START_THR:   start_thr   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Step logic for one frame
  always_comb begin
    logic [7:0] trial_base;
    cmd_e       cmd;
    status_e    st;
    logic       clr;

    phase_next         = phase;
    trial_counter_next = trial_counter;
    search_thr_next    = search_thr;
    active_next        = active;
    cmd                = CMD_NONE;
    st                 = ST_RUN;
    clr                = 1'b0;
    trial_base         = (search_thr == 8'd1) ? max_trials : trial_counter;

    if (item.trigger) begin
      case (phase)
        PH_IDLE:    phase_next = PH_START;
        PH_START: begin
          active_next     = 1'b1;
          search_thr_next = start_thr;
          cmd             = CMD_START;
          phase_next      = PH_PROGRAM;
        end
        PH_PROGRAM: begin
          cmd        = CMD_PROGRAM;
          phase_next = PH_DET_ON;
        end
        PH_DET_ON: begin
          cmd        = CMD_DET_ON;
          phase_next = PH_DET_OFF;
        end
        PH_DET_OFF: begin
          cmd        = CMD_DET_OFF;
          phase_next = PH_SETTLE;
        end
        PH_SETTLE:  phase_next = PH_EVAL;
        PH_EVAL: begin
          cmd = CMD_EVAL;
          if (trial_counter >= max_trials && item.defect_count <= upper_limit) begin
            st                 = ST_TIMEOUT;
            clr                = 1'b1;
            phase_next         = PH_IDLE;
            trial_counter_next = '0;
            active_next        = 1'b0;
          end else if (item.defect_count > upper_limit) begin
            st                 = ST_HIGHER;
            search_thr_next    = search_thr + 8'd1;
            trial_counter_next = trial_counter + 8'd1;
            phase_next         = PH_PROGRAM;
          end else if (item.defect_count < lower_limit) begin
            st                 = ST_LOWER;
            search_thr_next    = search_thr - 8'd1;
            trial_counter_next = trial_base + 8'd1;
            phase_next         = PH_PROGRAM;
          end else begin
            st                 = ST_SUCCESS;
            clr                = 1'b1;
            phase_next         = PH_IDLE;
            trial_counter_next = '0;
            active_next        = 1'b0;
          end
        end
        default: ;  // halted: hold everything
      endcase
    end else if (active) begin
      // trigger dropped mid-calibration
      cmd                = CMD_ABORT;
      phase_next         = PH_IDLE;
      trial_counter_next = '0;
      active_next        = 1'b0;
    end

    result_next.command       = cmd;
    result_next.threshold     = search_thr_next;
    result_next.status        = st;
    result_next.trigger_clear = clr;
    result_next.calibrating   = active_next;
    result_next.trials        = trial_counter_next;
  end

  // State update on each item transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      trial_counter <= '0;
      search_thr    <= '0;
      active        <= 1'b0;
    end else if (item_xfer) begin
      phase         <= phase_next;
      trial_counter <= trial_counter_next;
      search_thr    <= search_thr_next;
      active        <= active_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (item_xfer) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_xfer) begin
      result <= result_next;
    end
  end

  // Checks
  `DPC_ASSERT_NEXT(a_xfer_gives_result, item_xfer, result_valid,
    "item transfer did not produce a result")
  `DPC_ASSERT_NOW(a_finish_clears, result_valid && (result.status == ST_SUCCESS ||
    result.status == ST_TIMEOUT), result.trigger_clear && !result.calibrating &&
    result.trials == 8'd0, "finish did not clear calibration state")
  `DPC_ASSERT_NOW(a_status_only_on_eval, result_valid && result.status != ST_RUN,
    result.command == CMD_EVAL, "status reported outside evaluation")
  `DPC_ASSERT_NOW(a_idle_no_trials, result_valid && !result.calibrating,
    result.trials == 8'd0, "trial count nonzero while not calibrating")
  `DPC_ASSERT_NOW(a_abort_clears, result_valid && result.command == CMD_ABORT,
    !result.calibrating && !result.trigger_clear, "abort left calibration active")

endmodule
